// File: design/wse_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Window selectivity estimate package
// Shared types and constants for the front, queue, divider and back units.
// ----------------------------------------------------------------------------
package wse_pkg;

  // Fixed field widths.
  localparam int unsigned CoordW = 32;
  localparam int unsigned ExtW   = 31;
  localparam int unsigned CardW  = 32;
  localparam int unsigned CountW = 24;
  localparam int unsigned SumW   = 48;
  localparam int unsigned DivW   = 64;
  localparam int unsigned StepW  = 7;

  // Divider step counts for the two kinds of quotient.
  localparam logic [StepW-1:0] ShrinkSteps = 7'd63;
  localparam logic [StepW-1:0] ProbSteps   = 7'd32;

  // Configuration register indexes.
  localparam logic [1:0] RegQMinX = 2'd0;
  localparam logic [1:0] RegQMinY = 2'd1;
  localparam logic [1:0] RegQMaxX = 2'd2;
  localparam logic [1:0] RegQMaxY = 2'd3;

  // A classified bucket as it leaves the front unit.
  typedef struct packed {
    logic              hit;
    logic              last;
    logic              wide;   // mean width larger than mean height
    logic [ExtW-1:0]   mw;
    logic [ExtW-1:0]   mh;
    logic [CountW-1:0] cnt;
    logic [CardW-1:0]  card;
    logic [CoordW-1:0] ux;
    logic [CoordW-1:0] uy;
    logic [CoordW-1:0] iw;
    logic [CoordW-1:0] ih;
  } item_t;

  // Queue status.
  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  // Request to the shared divider.
  typedef struct packed {
    logic             start;
    logic [DivW-1:0]  den;
    logic [DivW-1:0]  rem;
    logic [DivW-1:0]  dvd;
    logic [StepW-1:0] steps;
  } div_req_t;

  // Divider response.
  typedef struct packed {
    logic            done;
    logic [DivW-1:0] quo;
  } div_rsp_t;

endpackage

// File: design/wse_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Window selectivity estimate front unit
// Tests a bucket against the query window and forms its extents.
// ----------------------------------------------------------------------------
module wse_front (
  input  logic signed [31:0] q_min_x_i,
  input  logic signed [31:0] q_min_y_i,
  input  logic signed [31:0] q_max_x_i,
  input  logic signed [31:0] q_max_y_i,
  input  logic signed [31:0] area_min_x_i,
  input  logic signed [31:0] area_min_y_i,
  input  logic signed [31:0] area_max_x_i,
  input  logic signed [31:0] area_max_y_i,
  input  logic [30:0]        mean_width_i,
  input  logic [30:0]        mean_height_i,
  input  logic [31:0]        cardinality_i,
  input  logic [23:0]        object_count_i,
  input  logic               last_bucket_i,
  output wse_pkg::item_t     item_o
);
  import wse_pkg::*;

  logic signed [31:0] lo_x, hi_x, lo_y, hi_y;
  logic [32:0]        ux_w, uy_w, iw_w, ih_w;

  // Intersection test, touching edges included.
  assign item_o.hit = (q_min_x_i <= q_max_x_i) && (q_min_y_i <= q_max_y_i) &&
                      (area_min_x_i <= area_max_x_i) && (area_min_y_i <= area_max_y_i) &&
                      (area_min_x_i <= q_max_x_i) && (area_max_x_i >= q_min_x_i) &&
                      (area_min_y_i <= q_max_y_i) && (area_max_y_i >= q_min_y_i);

  // Overlap bounds per axis.
  assign lo_x = (area_min_x_i > q_min_x_i) ? area_min_x_i : q_min_x_i;
  assign hi_x = (area_max_x_i < q_max_x_i) ? area_max_x_i : q_max_x_i;
  assign lo_y = (area_min_y_i > q_min_y_i) ? area_min_y_i : q_min_y_i;
  assign hi_y = (area_max_y_i < q_max_y_i) ? area_max_y_i : q_max_y_i;

  // Extents are non-negative and fit 32 bits whenever the bucket hits.
  assign ux_w = {area_max_x_i[31], area_max_x_i} - {area_min_x_i[31], area_min_x_i};
  assign uy_w = {area_max_y_i[31], area_max_y_i} - {area_min_y_i[31], area_min_y_i};
  assign iw_w = {hi_x[31], hi_x} - {lo_x[31], lo_x};
  assign ih_w = {hi_y[31], hi_y} - {lo_y[31], lo_y};

  assign item_o.last = last_bucket_i;
  assign item_o.wide = mean_width_i > mean_height_i;
  assign item_o.mw   = mean_width_i;
  assign item_o.mh   = mean_height_i;
  assign item_o.cnt  = object_count_i;
  assign item_o.card = cardinality_i;
  assign item_o.ux   = ux_w[31:0];
  assign item_o.uy   = uy_w[31:0];
  assign item_o.iw   = iw_w[31:0];
  assign item_o.ih   = ih_w[31:0];

endmodule

// File: design/wse_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Window selectivity estimate bucket queue
// Two-entry queue that decouples the front unit from the back unit.
// ----------------------------------------------------------------------------
module wse_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_i,
  input  wse_pkg::item_t    wdata_i,
  input  logic              rd_i,
  output wse_pkg::item_t    rdata_o,
  output wse_pkg::q_stat_t  stat_o
);
  import wse_pkg::*;

  item_t      mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (wr_i) wptr_q <= ~wptr_q;
      if (rd_i) rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + {1'b0, wr_i} - {1'b0, rd_i};
    end
  end

  // Storage.
  always_ff @(posedge clk_i) begin
    if (wr_i) mem_q[wptr_q] <= wdata_i;
  end

  assign rdata_o      = mem_q[rptr_q];
  assign stat_o.empty = cnt_q == 2'd0;
  assign stat_o.full  = cnt_q == 2'd2;

endmodule

// File: design/wse_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Window selectivity estimate divider
// Restoring divider that retires one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wse_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  wse_pkg::div_req_t req_i,
  output wse_pkg::div_rsp_t rsp_o
);
  import wse_pkg::*;

  logic             busy_q, done_q;
  logic [StepW-1:0] cnt_q;
  logic [DivW-1:0]  rem_q, dvd_q, quo_q, den_q;
  logic [DivW:0]    rem2;
  logic [DivW+1:0]  diff;
  logic             ge;

  // One trial subtraction per cycle.
  assign rem2 = {rem_q, dvd_q[DivW-1]};
  assign diff = {1'b0, rem2} - {2'b00, den_q};
  assign ge   = ~diff[DivW+1];

  // Sequencing control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.steps;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == StepW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath.
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= req_i.rem;
      dvd_q <= req_i.dvd;
      den_q <= req_i.den;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DivW-1:0] : rem2[DivW-1:0];
      dvd_q <= {dvd_q[DivW-2:0], 1'b0};
      quo_q <= {quo_q[DivW-2:0], ge};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

endmodule

// File: design/wse_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Window selectivity estimate back unit
// Shrinks extents, forms probabilities, accumulates and emits the estimate.
// ----------------------------------------------------------------------------
module wse_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  wse_pkg::q_stat_t  q_stat_i,
  input  wse_pkg::item_t    q_item_i,
  output logic              q_rd_o,
  input  logic              pop_i,
  output logic              empty_o,
  output logic [47:0]       estimate_o
);
  import wse_pkg::*;

  localparam logic [3:0] StIdle = 4'd0;
  localparam logic [3:0] StMul1 = 4'd1;
  localparam logic [3:0] StMul2 = 4'd2;
  localparam logic [3:0] StShr  = 4'd3;
  localparam logic [3:0] StShrW = 4'd4;
  localparam logic [3:0] StPx   = 4'd5;
  localparam logic [3:0] StPxW  = 4'd6;
  localparam logic [3:0] StPy   = 4'd7;
  localparam logic [3:0] StPyW  = 4'd8;
  localparam logic [3:0] StSc1  = 4'd9;
  localparam logic [3:0] StSc2  = 4'd10;
  localparam logic [3:0] StAcc  = 4'd11;
  localparam logic [3:0] StLast = 4'd12;

  logic [3:0]       st_q, st_d;
  item_t            cur_q, cur_d;
  logic [62:0]      num_q, num_d;
  logic [54:0]      den_q, den_d;
  logic [ExtW-1:0]  ext_q, ext_d;
  logic [31:0]      px_q, px_d, py_q, py_d, t_q, t_d, c_q, c_d;
  logic             pxone_q, pxone_d, pyone_q, pyone_d;
  logic [SumW-1:0]  sum_q, sum_d, res_q, res_d;
  logic             vld_q, vld_d;
  div_req_t         dreq;
  div_rsp_t         drsp;

  logic [ExtW-1:0]  sh_a, sh_b, ex, ey;
  logic [31:0]      sh_u;
  logic [32:0]      numx, numy;
  logic [63:0]      prod;
  logic [SumW:0]    acc;

  wse_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (dreq),
    .rsp_o  (drsp)
  );

  // Operands of the shrink ratio depend on which extent is larger.
  assign sh_a = cur_q.wide ? cur_q.mw : cur_q.mh;
  assign sh_b = cur_q.wide ? cur_q.mh : cur_q.mw;
  assign sh_u = cur_q.wide ? cur_q.uy : cur_q.ux;
  assign ex   = cur_q.wide ? ext_q : cur_q.mw;
  assign ey   = cur_q.wide ? cur_q.mh : ext_q;
  assign numx = {2'b00, ex} + {1'b0, cur_q.iw};
  assign numy = {2'b00, ey} + {1'b0, cur_q.ih};

  // Shared multiplier for the two scaling steps.
  assign prod = (st_q == StSc1) ? (64'(cur_q.card) * 64'(px_q))
                                : (64'(t_q) * 64'(py_q));
  assign acc  = {1'b0, sum_q} + {17'd0, c_q};

  // Sequencer.
  always_comb begin
    st_d    = st_q;
    cur_d   = cur_q;
    num_d   = num_q;
    den_d   = den_q;
    ext_d   = ext_q;
    px_d    = px_q;
    py_d    = py_q;
    pxone_d = pxone_q;
    pyone_d = pyone_q;
    t_d     = t_q;
    c_d     = c_q;
    sum_d   = sum_q;
    res_d   = res_q;
    vld_d   = vld_q & ~pop_i;
    q_rd_o  = 1'b0;
    dreq    = '0;
    case (st_q)
      StIdle: begin
        if (!q_stat_i.empty) begin
          q_rd_o = 1'b1;
          cur_d  = q_item_i;
          st_d   = q_item_i.hit ? StMul1 : StLast;
        end
      end
      StMul1: begin
        num_d = 63'(sh_a) * 63'(sh_u);
        st_d  = StMul2;
      end
      StMul2: begin
        den_d = 55'(sh_b) * 55'(cur_q.cnt);
        st_d  = StShr;
      end
      StShr: begin
        // A zero denominator or a zero sh_u leaves the extent as it is.
        if (den_q == '0 || sh_u == '0) begin
          ext_d = sh_a;
          st_d  = StPx;
        end else begin
          dreq.start = 1'b1;
          dreq.den   = {9'd0, den_q};
          dreq.rem   = '0;
          dreq.dvd   = {num_q, 1'b0};
          dreq.steps = ShrinkSteps;
          st_d       = StShrW;
        end
      end
      StShrW: begin
        if (drsp.done) begin
          ext_d = (drsp.quo < {33'd0, sh_a}) ? drsp.quo[ExtW-1:0] : sh_a;
          st_d  = StPx;
        end
      end
      StPx: begin
        if (cur_q.ux == '0 || numx >= {1'b0, cur_q.ux}) begin
          pxone_d = 1'b1;
          st_d    = StPy;
        end else begin
          pxone_d    = 1'b0;
          dreq.start = 1'b1;
          dreq.den   = {32'd0, cur_q.ux};
          dreq.rem   = {31'd0, numx};
          dreq.dvd   = '0;
          dreq.steps = ProbSteps;
          st_d       = StPxW;
        end
      end
      StPxW: begin
        if (drsp.done) begin
          px_d = drsp.quo[31:0];
          st_d = StPy;
        end
      end
      StPy: begin
        if (cur_q.uy == '0 || numy >= {1'b0, cur_q.uy}) begin
          pyone_d = 1'b1;
          st_d    = StSc1;
        end else begin
          pyone_d    = 1'b0;
          dreq.start = 1'b1;
          dreq.den   = {32'd0, cur_q.uy};
          dreq.rem   = {31'd0, numy};
          dreq.dvd   = '0;
          dreq.steps = ProbSteps;
          st_d       = StPyW;
        end
      end
      StPyW: begin
        if (drsp.done) begin
          py_d = drsp.quo[31:0];
          st_d = StSc1;
        end
      end
      StSc1: begin
        t_d  = pxone_q ? cur_q.card : prod[63:32];
        st_d = StSc2;
      end
      StSc2: begin
        c_d  = pyone_q ? t_q : prod[63:32];
        st_d = StAcc;
      end
      StAcc: begin
        sum_d = acc[SumW] ? '1 : acc[SumW-1:0];
        st_d  = StLast;
      end
      StLast: begin
        // The final bucket hands the sum over once the result slot is free.
        if (!cur_q.last) begin
          st_d = StIdle;
        end else if (!vld_q || pop_i) begin
          res_d = sum_q;
          vld_d = 1'b1;
          sum_d = '0;
          st_d  = StIdle;
        end
      end
      default: st_d = StIdle;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= StIdle;
      sum_q <= '0;
      vld_q <= 1'b0;
    end else begin
      st_q  <= st_d;
      sum_q <= sum_d;
      vld_q <= vld_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    cur_q   <= cur_d;
    num_q   <= num_d;
    den_q   <= den_d;
    ext_q   <= ext_d;
    px_q    <= px_d;
    py_q    <= py_d;
    pxone_q <= pxone_d;
    pyone_q <= pyone_d;
    t_q     <= t_d;
    c_q     <= c_d;
    res_q   <= res_d;
  end

  assign empty_o    = ~vld_q;
  assign estimate_o = res_q;

endmodule

// File: design/window_selectivity_estimate.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Window selectivity estimate
// Accumulates a histogram window-query estimate over a stream of buckets.
// ----------------------------------------------------------------------------
// A bucket that misses the window skips the arithmetic in the back unit; one that
// hits is held there by the one-bit-per-cycle divider, which runs up to
// a 63-step shrink quotient and two 32-step probability quotients in turn.
// The result of a last bucket is registered into the result slot after its accumulation, once the slot is free.
// Reset clears the window, the running sum, the queue and the result slot.
module window_selectivity_estimate (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               push,
  output logic               full,
  input  logic signed [31:0] area_min_x_i,
  input  logic signed [31:0] area_min_y_i,
  input  logic signed [31:0] area_max_x_i,
  input  logic signed [31:0] area_max_y_i,
  input  logic [30:0]        mean_width_i,
  input  logic [30:0]        mean_height_i,
  input  logic [31:0]        cardinality_i,
  input  logic [23:0]        object_count_i,
  input  logic               last_bucket_i,
  output logic               empty,
  input  logic               pop,
  output logic [47:0]        estimate_o
);
  import wse_pkg::*;

  logic signed [31:0] qmin_x_q, qmin_y_q, qmax_x_q, qmax_y_q;
  item_t              f_item, b_item;
  q_stat_t            q_stat;
  logic               q_wr, q_rd;

  // Query window registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qmin_x_q <= '0;
      qmin_y_q <= '0;
      qmax_x_q <= '0;
      qmax_y_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegQMinX: qmin_x_q <= cfg_data_i;
        RegQMinY: qmin_y_q <= cfg_data_i;
        RegQMaxX: qmax_x_q <= cfg_data_i;
        RegQMaxY: qmax_y_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  wse_front u_front (
    .q_min_x_i      (qmin_x_q),
    .q_min_y_i      (qmin_y_q),
    .q_max_x_i      (qmax_x_q),
    .q_max_y_i      (qmax_y_q),
    .area_min_x_i   (area_min_x_i),
    .area_min_y_i   (area_min_y_i),
    .area_max_x_i   (area_max_x_i),
    .area_max_y_i   (area_max_y_i),
    .mean_width_i   (mean_width_i),
    .mean_height_i  (mean_height_i),
    .cardinality_i  (cardinality_i),
    .object_count_i (object_count_i),
    .last_bucket_i  (last_bucket_i),
    .item_o         (f_item)
  );

  // A transaction on the input side writes the queue.
  assign q_wr = push && !q_stat.full;
  assign full = q_stat.full;

  wse_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (q_wr),
    .wdata_i (f_item),
    .rd_i    (q_rd),
    .rdata_o (b_item),
    .stat_o  (q_stat)
  );

  wse_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_stat_i   (q_stat),
    .q_item_i   (b_item),
    .q_rd_o     (q_rd),
    .pop_i      (pop),
    .empty_o    (empty),
    .estimate_o (estimate_o)
  );

  // An accepted bucket is always in the queue on the next cycle.
  a_push_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_wr |=> !q_stat.empty)
    else $error("accepted bucket missing from queue");

  // The queue never reports empty and full together.
  a_q_stat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_stat.empty && q_stat.full))
    else $error("queue status inconsistent");

  // The back unit never reads an empty queue.
  a_no_underrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_rd |-> !q_stat.empty)
    else $error("queue read while empty");

endmodule
